/* rtl/prr_pkg.sv */
// Shared types and constants for the permutation rank/unrank block.
// No dependencies; used by prr_alu and permutation_rank_unrank.
`timescale 1ns / 1ps
`default_nettype none

package prr_pkg;

    localparam int MAX_LENGTH = 12;
    localparam int IDX_W      = $clog2(MAX_LENGTH);
    localparam int CNT_W      = $clog2(MAX_LENGTH + 1);
    localparam int ELEM_W     = 4;
    localparam int LEN_W      = 4;
    localparam int RANK_W     = 29;
    localparam int DIV_STEPS  = RANK_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam int IN_DATA_W  = ((ELEM_W + RANK_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((RANK_W + ELEM_W + 1 + 7) / 8) * 8;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [LEN_W-1:0]      LEN_RESET        = LEN_W'(8);
    localparam logic [APB_ADDR_W-1:0] ADDR_PERM_LENGTH = APB_ADDR_W'(0);

    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_UNRANK  = 1'b1;
    localparam logic KIND_RANK    = 1'b0;
    localparam logic KIND_ELEMENT = 1'b1;

    typedef enum logic {
        ALU_MUL,
        ALU_DIV
    } alu_op_t;

    typedef struct packed {
        logic              start;
        alu_op_t           op;
        logic [RANK_W-1:0] a;
        logic [CNT_W-1:0]  b;
    } alu_req_t;

    typedef struct packed {
        logic              done;
        logic [RANK_W-1:0] quo;
        logic [CNT_W-1:0]  rem;
    } alu_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RK_RD,
        ST_RK_MUL,
        ST_RK_ACC,
        ST_RK_WGT,
        ST_RK_OUT,
        ST_UR_INIT,
        ST_UR_DIV,
        ST_UR_DWAIT,
        ST_UR_RDJ,
        ST_UR_RDK,
        ST_UR_SWAP,
        ST_UR_RD0,
        ST_UR_FIN0,
        ST_UR_EMIT
    } state_t;

endpackage

`default_nettype wire

/* rtl/prr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module prr_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 12
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/prr_alu.sv */
// Shared arithmetic unit: registered narrow multiply, bit-serial restoring divide.
// Depends on prr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module prr_alu (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire prr_pkg::alu_req_t req,
    output prr_pkg::alu_rsp_t      rsp
);

    localparam int PROD_W = prr_pkg::RANK_W + prr_pkg::CNT_W;

    logic                                busy_reg, busy_next;
    logic                                done_reg, done_next;
    logic [prr_pkg::STEP_W-1:0]          cnt_reg, cnt_next;
    logic [prr_pkg::CNT_W-1:0]           div_reg, div_next;
    logic [prr_pkg::RANK_W-1:0]          quo_reg, quo_next;
    logic [prr_pkg::CNT_W-1:0]           rem_reg, rem_next;

    logic [prr_pkg::CNT_W:0]             trial;
    logic [prr_pkg::CNT_W:0]             diff;
    logic                                fits;
    logic [PROD_W-1:0]                   product;

    // partial remainder with the next dividend bit shifted in
    assign trial   = {rem_reg, quo_reg[prr_pkg::RANK_W-1]};
    assign fits    = trial >= {1'b0, div_reg};
    assign diff    = trial - {1'b0, div_reg};
    assign product = PROD_W'(req.a) * PROD_W'(req.b);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        div_next  = div_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (busy_reg)
        begin
            quo_next = {quo_reg[prr_pkg::RANK_W-2:0], fits};
            rem_next = fits ? prr_pkg::CNT_W'(diff) : prr_pkg::CNT_W'(trial);
            cnt_next = cnt_reg - prr_pkg::STEP_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            if (req.op == prr_pkg::ALU_MUL)
            begin
                quo_next  = prr_pkg::RANK_W'(product);
                done_next = 1'b1;
            end
            else
            begin
                quo_next  = req.a;
                rem_next  = '0;
                div_next  = req.b;
                cnt_next  = prr_pkg::STEP_W'(prr_pkg::DIV_STEPS - 1);
                busy_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        div_reg <= div_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("alu started while a divide is running");

endmodule

`default_nettype wire

/* rtl/permutation_rank_unrank.sv */
// Top level: permutation rank/unrank sequencer, load state and stream/APB ports.
// Depends on prr_pkg, prr_ram and prr_alu.
//
//   Channel   Direction  Payload
//   s_axis    in         tuser: func; tdata: element, rank_in
//   m_axis    out        tuser: kind; tlast: last; tdata: rank_out, element_out, not_perm
//   apb       in/out     perm_length at byte address 0
//
// Rank: one loaded element per cycle while idle, then per position a table read and two
// multiplier passes (RK_RD, RK_MUL, RK_ACC, RK_WGT); RK_OUT then sends the rank.
// Unrank: UR_INIT seeds the identity, each position runs the 29-step divider, UR_RD0 and
// UR_FIN0 fetch position 0, then one element per cycle is emitted while output is free.
// Reset clears the load state and sets perm_length to 8; tables need no clearing.
// s_axis_tready is low during a request; a full output register holds the sequencer.
`timescale 1ns / 1ps
`default_nettype none

module permutation_rank_unrank (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [prr_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [prr_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [prr_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                    pready,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [3:0] element, [32:4] rank_in, rest zero
    input  wire logic [prr_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [0] func
    input  wire logic                               s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [28:0] rank_out, [32:29] element_out, [33] not_perm, rest zero
    output logic      [prr_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // [0] kind
    output logic                                    m_axis_tuser,
    output logic                                    m_axis_tlast
);

    localparam int MAXL   = prr_pkg::MAX_LENGTH;
    localparam int IDX_W  = prr_pkg::IDX_W;
    localparam int CNT_W  = prr_pkg::CNT_W;
    localparam int ELEM_W = prr_pkg::ELEM_W;
    localparam int LEN_W  = prr_pkg::LEN_W;
    localparam int RANK_W = prr_pkg::RANK_W;
    localparam int PAD_W  = prr_pkg::OUT_DATA_W - (RANK_W + ELEM_W + 1);

    prr_pkg::state_t state_reg, state_next;

    logic [LEN_W-1:0]  len_reg, len_next;
    logic [CNT_W-1:0]  load_count_reg, load_count_next;
    logic [MAXL-1:0]   seen_reg, seen_next;

    logic [CNT_W-1:0]  k_reg, k_next;
    logic [RANK_W-1:0] w_reg, w_next;
    logic [RANK_W-1:0] rank_reg, rank_next;
    logic [RANK_W-1:0] x_reg, x_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic [ELEM_W-1:0] dj_reg, dj_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              bad_reg, bad_next;
    logic [ELEM_W-1:0] fin_reg [MAXL];

    logic              out_valid_reg, out_valid_next;
    logic              out_kind_reg, out_kind_next;
    logic              out_last_reg, out_last_next;
    logic              out_np_reg, out_np_next;
    logic [RANK_W-1:0] out_rank_reg, out_rank_next;
    logic [ELEM_W-1:0] out_elem_reg, out_elem_next;

    logic              in_accept;
    logic              in_func;
    logic [ELEM_W-1:0] in_elem;
    logic [RANK_W-1:0] in_rank;
    logic              cfg_write;
    logic [CNT_W-1:0]  n_eff;
    logic [MAXL-1:0]   full_mask;
    logic              elem_ok;
    logic [MAXL-1:0]   new_seen;
    logic [CNT_W-1:0]  count_inc;
    logic              load_done;
    logic              load_bad;
    logic              slot_free;
    logic              out_load;

    logic              elem_we, inv_we, perm_we, fin_we;
    logic [IDX_W-1:0]  elem_waddr, inv_waddr, perm_waddr, fin_waddr;
    logic [ELEM_W-1:0] elem_wdata, perm_wdata, fin_wdata;
    logic [IDX_W-1:0]  inv_wdata;
    logic [IDX_W-1:0]  step_raddr, perm_raddr;
    logic [ELEM_W-1:0] elem_rdata, perm_rdata;
    logic [IDX_W-1:0]  inv_rdata;

    prr_pkg::alu_req_t alu_req;
    prr_pkg::alu_rsp_t alu_rsp;

    assign in_func   = s_axis_tuser;
    assign in_elem   = s_axis_tdata[ELEM_W-1:0];
    assign in_rank   = s_axis_tdata[ELEM_W +: RANK_W];
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == prr_pkg::ST_IDLE);

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == prr_pkg::ADDR_PERM_LENGTH);
    assign prdata    = (paddr == prr_pkg::ADDR_PERM_LENGTH) ?
                       prr_pkg::APB_DATA_W'(len_reg) : '0;

    // length clamp: zero acts as one, oversize acts as the maximum
    always_comb
    begin
        if (len_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (32'(len_reg) > MAXL)
        begin
            n_eff = CNT_W'(MAXL);
        end
        else
        begin
            n_eff = CNT_W'(len_reg);
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAXL; i++)
        begin
            full_mask[i] = (CNT_W'(i) < n_eff);
        end
    end

    assign elem_ok   = 32'(in_elem) < 32'(n_eff);
    assign new_seen  = seen_reg | (elem_ok ? (MAXL'(1) << IDX_W'(in_elem)) : '0);
    assign count_inc = load_count_reg + CNT_W'(1);
    assign load_done = (count_inc == n_eff);
    assign load_bad  = (new_seen != full_mask);
    assign slot_free = !out_valid_reg || m_axis_tready;

    prr_ram #(.WIDTH(ELEM_W), .DEPTH(MAXL)) u_elem_ram (
        .clk   (clk),
        .we    (elem_we),
        .waddr (elem_waddr),
        .wdata (elem_wdata),
        .raddr (step_raddr),
        .rdata (elem_rdata)
    );

    prr_ram #(.WIDTH(IDX_W), .DEPTH(MAXL)) u_inv_ram (
        .clk   (clk),
        .we    (inv_we),
        .waddr (inv_waddr),
        .wdata (inv_wdata),
        .raddr (step_raddr),
        .rdata (inv_rdata)
    );

    prr_ram #(.WIDTH(ELEM_W), .DEPTH(MAXL)) u_perm_ram (
        .clk   (clk),
        .we    (perm_we),
        .waddr (perm_waddr),
        .wdata (perm_wdata),
        .raddr (perm_raddr),
        .rdata (perm_rdata)
    );

    prr_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            prr_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_func == prr_pkg::FUNC_UNRANK)
                    begin
                        state_next = prr_pkg::ST_UR_INIT;
                    end
                    else if (load_done)
                    begin
                        state_next = (load_bad || n_eff == CNT_W'(1)) ?
                                     prr_pkg::ST_RK_OUT : prr_pkg::ST_RK_RD;
                    end
                end
            end
            prr_pkg::ST_RK_RD:   state_next = prr_pkg::ST_RK_MUL;
            prr_pkg::ST_RK_MUL:  state_next = prr_pkg::ST_RK_ACC;
            prr_pkg::ST_RK_ACC:
            begin
                if (alu_rsp.done)
                begin
                    state_next = prr_pkg::ST_RK_WGT;
                end
            end
            prr_pkg::ST_RK_WGT:
            begin
                if (alu_rsp.done)
                begin
                    state_next = (k_reg > CNT_W'(2)) ? prr_pkg::ST_RK_RD : prr_pkg::ST_RK_OUT;
                end
            end
            prr_pkg::ST_RK_OUT:
            begin
                if (slot_free)
                begin
                    state_next = prr_pkg::ST_IDLE;
                end
            end
            prr_pkg::ST_UR_INIT:
            begin
                if (idx_reg == n_eff - CNT_W'(1))
                begin
                    state_next = (n_eff > CNT_W'(1)) ? prr_pkg::ST_UR_DIV : prr_pkg::ST_UR_RD0;
                end
            end
            prr_pkg::ST_UR_DIV:  state_next = prr_pkg::ST_UR_DWAIT;
            prr_pkg::ST_UR_DWAIT:
            begin
                if (alu_rsp.done)
                begin
                    state_next = prr_pkg::ST_UR_RDJ;
                end
            end
            prr_pkg::ST_UR_RDJ:  state_next = prr_pkg::ST_UR_RDK;
            prr_pkg::ST_UR_RDK:  state_next = prr_pkg::ST_UR_SWAP;
            prr_pkg::ST_UR_SWAP:
            begin
                state_next = (k_reg > CNT_W'(2)) ? prr_pkg::ST_UR_DIV : prr_pkg::ST_UR_RD0;
            end
            prr_pkg::ST_UR_RD0:  state_next = prr_pkg::ST_UR_FIN0;
            prr_pkg::ST_UR_FIN0: state_next = prr_pkg::ST_UR_EMIT;
            prr_pkg::ST_UR_EMIT:
            begin
                if (slot_free && idx_reg == n_eff - CNT_W'(1))
                begin
                    state_next = prr_pkg::ST_IDLE;
                end
            end
            default:             state_next = prr_pkg::ST_IDLE;
        endcase
    end

    // table, multiplier/divider and output strobes
    always_comb
    begin
        elem_we    = 1'b0;
        elem_waddr = IDX_W'(load_count_reg);
        elem_wdata = in_elem;
        inv_we     = 1'b0;
        inv_waddr  = IDX_W'(in_elem);
        inv_wdata  = IDX_W'(load_count_reg);
        step_raddr = IDX_W'(k_reg - CNT_W'(1));
        perm_we    = 1'b0;
        perm_waddr = IDX_W'(idx_reg);
        perm_wdata = ELEM_W'(idx_reg);
        perm_raddr = IDX_W'(k_reg - CNT_W'(1));
        fin_we     = 1'b0;
        fin_waddr  = IDX_W'(k_reg - CNT_W'(1));
        fin_wdata  = dj_reg;
        out_load   = 1'b0;
        alu_req.start = 1'b0;
        alu_req.op    = prr_pkg::ALU_MUL;
        alu_req.a     = w_reg;
        alu_req.b     = k_reg;
        case (state_reg)
            prr_pkg::ST_IDLE:
            begin
                if (in_accept && in_func == prr_pkg::FUNC_LOAD)
                begin
                    elem_we = 1'b1;
                    inv_we  = elem_ok;
                end
            end
            prr_pkg::ST_RK_MUL:
            begin
                // s = element at k-1, p = position of value k-1; move s into p
                elem_we       = 1'b1;
                elem_waddr    = inv_rdata;
                elem_wdata    = elem_rdata;
                inv_we        = 1'b1;
                inv_waddr     = IDX_W'(elem_rdata);
                inv_wdata     = inv_rdata;
                alu_req.start = 1'b1;
                alu_req.b     = CNT_W'(elem_rdata);
            end
            prr_pkg::ST_RK_ACC:
            begin
                alu_req.start = alu_rsp.done;
            end
            prr_pkg::ST_RK_OUT:
            begin
                out_load = slot_free;
            end
            prr_pkg::ST_UR_INIT:
            begin
                perm_we = 1'b1;
            end
            prr_pkg::ST_UR_DIV:
            begin
                alu_req.start = 1'b1;
                alu_req.op    = prr_pkg::ALU_DIV;
                alu_req.a     = x_reg;
            end
            prr_pkg::ST_UR_RDJ:
            begin
                perm_raddr = j_reg;
            end
            prr_pkg::ST_UR_SWAP:
            begin
                perm_we    = 1'b1;
                perm_waddr = j_reg;
                perm_wdata = perm_rdata;
                fin_we     = 1'b1;
            end
            prr_pkg::ST_UR_RD0:
            begin
                perm_raddr = '0;
            end
            prr_pkg::ST_UR_FIN0:
            begin
                fin_we    = 1'b1;
                fin_waddr = '0;
                fin_wdata = perm_rdata;
            end
            prr_pkg::ST_UR_EMIT:
            begin
                out_load = slot_free;
            end
            default:
            begin
            end
        endcase
    end

    // datapath and load state
    always_comb
    begin
        len_next        = len_reg;
        load_count_next = load_count_reg;
        seen_next       = seen_reg;
        k_next          = k_reg;
        w_next          = w_reg;
        rank_next       = rank_reg;
        x_next          = x_reg;
        j_next          = j_reg;
        dj_next         = dj_reg;
        idx_next        = idx_reg;
        bad_next        = bad_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_kind_next   = out_kind_reg;
        out_last_next   = out_last_reg;
        out_np_next     = out_np_reg;
        out_rank_next   = out_rank_reg;
        out_elem_next   = out_elem_reg;
        case (state_reg)
            prr_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_func == prr_pkg::FUNC_UNRANK)
                    begin
                        idx_next = '0;
                        x_next   = in_rank;
                        k_next   = n_eff;
                    end
                    else if (load_done)
                    begin
                        load_count_next = '0;
                        seen_next       = '0;
                        k_next          = n_eff;
                        w_next          = RANK_W'(1);
                        rank_next       = '0;
                        bad_next        = load_bad;
                    end
                    else
                    begin
                        load_count_next = count_inc;
                        seen_next       = new_seen;
                    end
                end
            end
            prr_pkg::ST_RK_ACC:
            begin
                if (alu_rsp.done)
                begin
                    rank_next = rank_reg + alu_rsp.quo;
                end
            end
            prr_pkg::ST_RK_WGT:
            begin
                if (alu_rsp.done)
                begin
                    w_next = alu_rsp.quo;
                    k_next = k_reg - CNT_W'(1);
                end
            end
            prr_pkg::ST_UR_INIT:
            begin
                idx_next = idx_reg + CNT_W'(1);
            end
            prr_pkg::ST_UR_DWAIT:
            begin
                if (alu_rsp.done)
                begin
                    x_next = alu_rsp.quo;
                    j_next = IDX_W'(alu_rsp.rem);
                end
            end
            prr_pkg::ST_UR_RDK:
            begin
                dj_next = perm_rdata;
            end
            prr_pkg::ST_UR_SWAP:
            begin
                k_next = k_reg - CNT_W'(1);
            end
            prr_pkg::ST_UR_FIN0:
            begin
                idx_next = '0;
            end
            prr_pkg::ST_UR_EMIT:
            begin
                if (slot_free)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            default:
            begin
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
            if (state_reg == prr_pkg::ST_RK_OUT)
            begin
                out_kind_next = prr_pkg::KIND_RANK;
                out_last_next = 1'b1;
                out_np_next   = bad_reg;
                out_rank_next = bad_reg ? '0 : rank_reg;
                out_elem_next = '0;
            end
            else
            begin
                out_kind_next = prr_pkg::KIND_ELEMENT;
                out_last_next = (idx_reg == n_eff - CNT_W'(1));
                out_np_next   = 1'b0;
                out_rank_next = '0;
                out_elem_next = fin_reg[IDX_W'(idx_reg)];
            end
        end

        // a length write abandons any partial load
        if (cfg_write)
        begin
            len_next        = pwdata[LEN_W-1:0];
            load_count_next = '0;
            seen_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= prr_pkg::ST_IDLE;
            len_reg        <= prr_pkg::LEN_RESET;
            load_count_reg <= '0;
            seen_reg       <= '0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            len_reg        <= len_next;
            load_count_reg <= load_count_next;
            seen_reg       <= seen_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg        <= k_next;
        w_reg        <= w_next;
        rank_reg     <= rank_next;
        x_reg        <= x_next;
        j_reg        <= j_next;
        dj_reg       <= dj_next;
        bad_reg      <= bad_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
        out_np_reg   <= out_np_next;
        out_rank_reg <= out_rank_next;
        out_elem_reg <= out_elem_next;
        if (fin_we)
        begin
            fin_reg[fin_waddr] <= fin_wdata;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {PAD_W'(0), out_np_reg, out_elem_reg, out_rank_reg};

    a_alu_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        alu_rsp.done |-> (state_reg == prr_pkg::ST_RK_ACC ||
                          state_reg == prr_pkg::ST_RK_WGT ||
                          state_reg == prr_pkg::ST_UR_DWAIT))
        else $error("alu result arrived outside a wait state");

    a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == prr_pkg::ST_IDLE) |-> (load_count_reg < n_eff))
        else $error("load count reached the permutation length while idle");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == prr_pkg::ST_RK_RD || state_reg == prr_pkg::ST_UR_DIV) |->
        (k_reg >= CNT_W'(2) && k_reg <= n_eff))
        else $error("step position out of range");

    a_last_ends_request: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_last_next) |=> (state_reg == prr_pkg::ST_IDLE))
        else $error("sequencer still busy after the last result of a request");

endmodule

`default_nettype wire
